// ===== rtl/vpc_pkg.sv =====
package vpc_pkg;

    // Video memory geometry.
    localparam int VRAM_BYTES = 131072;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);

    typedef logic [VRAM_AW-1:0] t_vaddr;

    localparam t_vaddr VRAM_LAST = t_vaddr'(VRAM_BYTES - 1);

    // Port function codes as they arrive on the input channel.
    localparam logic [2:0] FN_DREAD    = 3'd0;
    localparam logic [2:0] FN_DWRITE   = 3'd1;
    localparam logic [2:0] FN_CTRL     = 3'd2;
    localparam logic [2:0] FN_STATUS   = 3'd3;
    localparam logic [2:0] FN_PALETTE  = 3'd4;
    localparam logic [2:0] FN_INDIRECT = 3'd5;
    localparam logic [2:0] FN_VBLANK   = 3'd6;

    // Register numbers that have a meaning inside this block.
    localparam logic [5:0] REG_MODE0      = 6'd0;
    localparam logic [5:0] REG_MODE1      = 6'd1;
    localparam logic [5:0] REG_BACKDROP   = 6'd7;
    localparam logic [5:0] REG_ADDR_HI    = 6'd14;
    localparam logic [5:0] REG_STATUS_SEL = 6'd15;
    localparam logic [5:0] REG_PAL_PTR    = 6'd16;
    localparam logic [5:0] REG_INDIRECT   = 6'd17;

    // Status register selectors.
    localparam logic [3:0] ST_FRAME   = 4'd0;
    localparam logic [3:0] ST_VSTAT   = 4'd2;
    localparam logic [3:0] ST_SEL_MAX = 4'd9;

    localparam logic [7:0] ST_VSTAT_RESET = 8'h80;
    localparam logic [7:0] ST_OUT_RANGE   = 8'hFF;

    // Classified operation handed from the front to the back.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DREAD,
        OP_DWRITE,
        OP_CTRL,
        OP_STATUS,
        OP_PALETTE,
        OP_INDIRECT,
        OP_VBLANK
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] wdata;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

    typedef struct packed {
        logic clearing;
        logic pop;
    } t_back_stat;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_RUN,
        BK_FILL
    } t_back_state;

    // Power-on palette, packed as R, G, B in octal digits.
    localparam logic [8:0] PAL_RESET [16] = '{
        9'o000, 9'o000, 9'o161, 9'o373, 9'o117, 9'o237, 9'o511, 9'o267,
        9'o711, 9'o733, 9'o661, 9'o664, 9'o141, 9'o625, 9'o555, 9'o777
    };

    // Display modes that use the full 17-bit address.
    function automatic logic f_wide(input logic [7:0] cr0, input logic [7:0] cr1);
        logic [4:0] m;
        m = {cr0[3:1], cr1[3], cr1[4]};
        return (m == 5'h08) || (m == 5'h09) || (m == 5'h0C) ||
               (m == 5'h10) || (m == 5'h14) || (m == 5'h1C);
    endfunction

    function automatic t_vaddr f_advance(input t_vaddr a, input logic wide);
        t_vaddr r;
        if (wide) begin
            r = a + t_vaddr'(1);
        end else begin
            r = {a[VRAM_AW-1:14], a[13:0] + 14'd1};
        end
        return r;
    endfunction

    function automatic logic [7:0] f_expand3(input logic [2:0] c);
        return {c, c, c[2:1]};
    endfunction

    function automatic logic [23:0] f_backdrop(input logic [8:0] p);
        return {f_expand3(p[8:6]), f_expand3(p[5:3]), f_expand3(p[2:0])};
    endfunction

endpackage

// ===== rtl/vpc_in_if.sv =====
interface vpc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] wdata;

    modport source (output valid, output func, output wdata, input ready);
    modport sink   (input valid, input func, input wdata, output ready);
endinterface

// ===== rtl/vpc_out_if.sv =====
interface vpc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rdata;
    logic        irq_pulse;
    logic [23:0] backdrop_rgb;

    modport source (output valid, output rdata, output irq_pulse, output backdrop_rgb,
                    input ready);
    modport sink   (input valid, input rdata, input irq_pulse, input backdrop_rgb,
                    output ready);
endinterface

// ===== rtl/vpc_ram.sv =====
module vpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 131072
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/vpc_front.sv =====
module vpc_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    vpc_in_if.sink              i_in,
    input  vpc_pkg::t_back_stat i_bk,
    output vpc_pkg::t_queue_out o_q
);
    import vpc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    t_item         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          push;
    logic          pop;
    t_item         in_item;

    function automatic t_op f_classify(input logic [2:0] func);
        t_op op;
        unique case (func)
            FN_DREAD:    op = OP_DREAD;
            FN_DWRITE:   op = OP_DWRITE;
            FN_CTRL:     op = OP_CTRL;
            FN_STATUS:   op = OP_STATUS;
            FN_PALETTE:  op = OP_PALETTE;
            FN_INDIRECT: op = OP_INDIRECT;
            FN_VBLANK:   op = OP_VBLANK;
            default:     op = OP_NONE;
        endcase
        return op;
    endfunction

    assign i_in.ready = (r_count != CNT_FULL) && !i_bk.clearing;
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_bk.pop;
    assign in_item    = '{op: f_classify(i_in.func), wdata: i_in.wdata};

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.item  = r_mem[r_rd_ptr];
endmodule

// ===== rtl/vpc_back.sv =====
module vpc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vpc_pkg::t_queue_out i_q,
    output vpc_pkg::t_back_stat o_bk,
    vpc_out_if.source           o_out
);
    import vpc_pkg::*;

    t_back_state r_state, n_state;
    t_vaddr      r_clr_cnt, n_clr_cnt;

    // Registers that the port logic reads; writes to others have no effect.
    logic [7:0] r_cr0, n_cr0;
    logic [7:0] r_cr1, n_cr1;
    logic [7:0] r_cr7, n_cr7;
    logic [7:0] r_cr14, n_cr14;
    logic [7:0] r_cr15, n_cr15;
    logic [7:0] r_cr16, n_cr16;
    logic [7:0] r_cr17, n_cr17;
    logic [7:0] r_st0, n_st0;
    logic [7:0] r_st2, n_st2;

    t_vaddr     r_addr, n_addr;
    logic [7:0] r_pref, n_pref;
    logic [7:0] r_cfb, n_cfb;
    logic       r_cfh, n_cfh;
    logic [7:0] r_pfb, n_pfb;
    logic       r_pfh, n_pfh;
    logic [8:0] r_pal [16];
    logic [8:0] n_pal [16];

    logic        r_ov, n_ov;
    logic [7:0]  r_ord, n_ord;
    logic        r_oirq, n_oirq;
    logic [23:0] r_obd, n_obd;

    logic       ram_we;
    t_vaddr     ram_waddr;
    logic [7:0] ram_wdata;
    t_vaddr     ram_raddr;
    logic [7:0] ram_rdata;

    logic       pop;
    logic       rw_en;
    logic [5:0] rw_num;
    logic [7:0] rw_val;
    logic [7:0] res_rdata;
    logic       res_irq;
    logic [7:0] v;
    t_vaddr     setup_addr;
    logic [3:0] s_sel;
    logic [3:0] pidx;
    logic [5:0] ind_num;
    logic       wide;

    vpc_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_BYTES)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_cr0     = r_cr0;
        n_cr1     = r_cr1;
        n_cr7     = r_cr7;
        n_cr14    = r_cr14;
        n_cr15    = r_cr15;
        n_cr16    = r_cr16;
        n_cr17    = r_cr17;
        n_st0     = r_st0;
        n_st2     = r_st2;
        n_addr    = r_addr;
        n_pref    = r_pref;
        n_cfb     = r_cfb;
        n_cfh     = r_cfh;
        n_pfb     = r_pfb;
        n_pfh     = r_pfh;
        n_pal     = r_pal;
        n_ov      = r_ov && !o_out.ready;
        n_ord     = r_ord;
        n_oirq    = r_oirq;
        n_obd     = r_obd;

        v          = i_q.item.wdata;
        setup_addr = {r_cr14[2:0], v[5:0], r_cfb};
        s_sel      = r_cr15[3:0];
        pidx       = r_cr16[3:0];
        ind_num    = r_cr17[5:0];
        wide       = f_wide(r_cr0, r_cr1);

        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = v;
        ram_raddr = r_addr;

        pop       = 1'b0;
        rw_en     = 1'b0;
        rw_num    = '0;
        rw_val    = '0;
        res_rdata = '0;
        res_irq   = 1'b0;

        unique case (r_state)
            BK_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_cnt;
                ram_wdata = '0;
                n_clr_cnt = r_clr_cnt + t_vaddr'(1);
                if (r_clr_cnt == VRAM_LAST) begin
                    n_state = BK_RUN;
                end
            end
            BK_FILL: begin
                n_pref  = ram_rdata;
                n_state = BK_RUN;
            end
            BK_RUN: begin
                if (i_q.valid && (!r_ov || o_out.ready)) begin
                    pop  = 1'b1;
                    n_ov = 1'b1;
                    unique case (i_q.item.op)
                        OP_DREAD: begin
                            n_cfh     = 1'b0;
                            res_rdata = r_pref;
                            ram_raddr = r_addr;
                            n_addr    = f_advance(r_addr, wide);
                            n_state   = BK_FILL;
                        end
                        OP_DWRITE: begin
                            n_cfh  = 1'b0;
                            ram_we = 1'b1;
                            n_addr = f_advance(r_addr, wide);
                        end
                        OP_CTRL: begin
                            if (!r_cfh) begin
                                n_cfb = v;
                                n_cfh = 1'b1;
                            end else begin
                                n_cfh = 1'b0;
                                if (v[7]) begin
                                    rw_en  = 1'b1;
                                    rw_num = v[5:0];
                                    rw_val = r_cfb;
                                end else if (v[6]) begin
                                    n_addr = setup_addr;
                                end else begin
                                    ram_raddr = setup_addr;
                                    n_addr    = f_advance(setup_addr, wide);
                                    n_state   = BK_FILL;
                                end
                            end
                        end
                        OP_STATUS: begin
                            n_cfh = 1'b0;
                            if (s_sel > ST_SEL_MAX) begin
                                res_rdata = ST_OUT_RANGE;
                            end else if (s_sel == ST_FRAME) begin
                                res_rdata = r_st0;
                                n_st0     = '0;
                            end else if (s_sel == ST_VSTAT) begin
                                res_rdata = r_st2;
                            end
                        end
                        OP_PALETTE: begin
                            if (!r_pfh) begin
                                n_pfb = v;
                                n_pfh = 1'b1;
                            end else begin
                                n_pfh       = 1'b0;
                                n_pal[pidx] = {r_pfb[6:4], v[2:0], r_pfb[2:0]};
                                n_cr16      = {4'd0, pidx + 4'd1};
                            end
                        end
                        OP_INDIRECT: begin
                            if (ind_num != REG_INDIRECT) begin
                                rw_en  = 1'b1;
                                rw_num = ind_num;
                                rw_val = v;
                            end
                            if (!r_cr17[7]) begin
                                n_cr17 = {r_cr17[7], 1'b0, ind_num + 6'd1};
                            end
                        end
                        OP_VBLANK: begin
                            n_st0[7] = 1'b1;
                            n_st2[6] = 1'b1;
                            res_irq  = r_cr1[5];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        // Register write and its side effects.
        if (rw_en) begin
            unique case (rw_num)
                REG_MODE0: n_cr0 = rw_val;
                REG_MODE1: begin
                    n_cr1   = rw_val;
                    res_irq = !r_cr1[5] && rw_val[5] && r_st0[7];
                end
                REG_BACKDROP: n_cr7 = rw_val;
                REG_ADDR_HI: begin
                    n_cr14 = rw_val;
                    n_addr = {rw_val[2:0], r_addr[13:0]};
                end
                REG_STATUS_SEL: n_cr15 = rw_val;
                REG_PAL_PTR: begin
                    n_cr16 = rw_val;
                    n_pfh  = 1'b0;
                end
                REG_INDIRECT: n_cr17 = rw_val;
                default: begin
                end
            endcase
        end

        if (pop) begin
            n_ord  = res_rdata;
            n_oirq = res_irq;
            n_obd  = f_backdrop(n_pal[n_cr7[3:0]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_CLEAR;
            r_clr_cnt <= '0;
            r_cr0     <= '0;
            r_cr1     <= '0;
            r_cr7     <= '0;
            r_cr14    <= '0;
            r_cr15    <= '0;
            r_cr16    <= '0;
            r_cr17    <= '0;
            r_st0     <= '0;
            r_st2     <= ST_VSTAT_RESET;
            r_addr    <= '0;
            r_pref    <= '0;
            r_cfb     <= '0;
            r_cfh     <= 1'b0;
            r_pfb     <= '0;
            r_pfh     <= 1'b0;
            r_pal     <= PAL_RESET;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_cr0     <= n_cr0;
            r_cr1     <= n_cr1;
            r_cr7     <= n_cr7;
            r_cr14    <= n_cr14;
            r_cr15    <= n_cr15;
            r_cr16    <= n_cr16;
            r_cr17    <= n_cr17;
            r_st0     <= n_st0;
            r_st2     <= n_st2;
            r_addr    <= n_addr;
            r_pref    <= n_pref;
            r_cfb     <= n_cfb;
            r_cfh     <= n_cfh;
            r_pfb     <= n_pfb;
            r_pfh     <= n_pfh;
            r_pal     <= n_pal;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ord  <= n_ord;
        r_oirq <= n_oirq;
        r_obd  <= n_obd;
    end

    assign o_bk.clearing = (r_state == BK_CLEAR);
    assign o_bk.pop      = pop;

    assign o_out.valid        = r_ov;
    assign o_out.rdata        = r_ord;
    assign o_out.irq_pulse    = r_oirq;
    assign o_out.backdrop_rgb = r_obd;
endmodule

// ===== rtl/video_processor_cpu_ports.sv =====
// A transaction accepted at the input is stored in the queue, then executed by the back end,
// which writes its result into its output register.
// Throughput: one transaction per cycle unless the output stalls; a data read or a read address
// setup also needs the fill state, where the registered read port delivers the prefetch byte.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to all 131072 video
// memory bytes, one per cycle, and no input transaction is accepted until it has finished.
module video_processor_cpu_ports #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vpc_in_if.sink    i_in,
    vpc_out_if.source o_out
);
    import vpc_pkg::*;

    // The block is split into a front end and an execution back end. The front end
    // accepts port transactions, decodes the function code into an operation and places
    // it in a short queue. The back end owns all architectural state: the video memory,
    // the control and status registers, the access address with its read-ahead byte,
    // the two-byte latches and the palette. It executes one queued operation per cycle
    // unless the output stalls, adds a fill state when a byte must come from video memory,
    // and writes the result into an output register. The queue lets the input flow on while
    // a result waits for the consumer, and lets the back end run while the input is idle.

    t_queue_out s_q;
    t_back_stat s_bk;

    vpc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_bk    (s_bk),
        .o_q     (s_q)
    );

    vpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (s_q),
        .o_bk    (s_bk),
        .o_out   (o_out)
    );

    // No transaction enters while the video memory is still being cleared.
    a_no_accept_in_clear : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        s_bk.clearing |-> !(i_in.valid && i_in.ready)
    ) else $error("input transaction accepted during the clearing pass");

    // The back end only takes an operation that the queue actually holds.
    a_pop_needs_entry : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        s_bk.pop |-> s_q.valid
    ) else $error("queue popped while empty");

    // The queue only drains through the back end.
    a_queue_drains_by_pop : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_q.valid) |-> $past(s_bk.pop)
    ) else $error("queue emptied without a pop");

    // The back end never runs while clearing.
    a_no_pop_in_clear : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        s_bk.clearing |-> !s_bk.pop
    ) else $error("operation executed during the clearing pass");
endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vpc_pkg::*;

    // Function code 7 is left unused by the port decoder; it must change nothing.
    localparam logic [2:0] FN_UNUSED = 3'd7;
    // Status 1 loses its bit 0 when read.
    localparam logic [3:0] ST_LINE = 4'd1;

    // The limit covers the clearing pass after reset and then each of the roughly
    // 580 transactions with its time in the block, its sender gap and its receiver stall.
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 550;
    localparam int DRAIN_CYCLES = 10;

    // Power-on colours as R, G and B octal digits.
    localparam logic [8:0] BOOT_PALETTE [16] = '{
        9'o000, 9'o000, 9'o161, 9'o373, 9'o117, 9'o237, 9'o511, 9'o267,
        9'o711, 9'o733, 9'o661, 9'o664, 9'o141, 9'o625, 9'o555, 9'o777
    };

    typedef struct packed {
        logic [2:0] fn;
        logic [7:0] wd;
    } t_port_access;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        irq;
        logic [23:0] rgb;
    } t_port_reply;

    logic i_clk;
    logic i_rst_n = 1'b0;

    // The channel inputs are held in local variables with known start values
    // and carried onto the interfaces by continuous assignments.
    logic       in_valid = 1'b0;
    logic [2:0] in_func  = FN_DREAD;
    logic [7:0] in_wdata = 8'h00;
    logic       out_ready = 1'b0;

    vpc_in_if  cpu_in ();
    vpc_out_if cpu_out ();

    assign cpu_in.valid  = in_valid;
    assign cpu_in.func   = in_func;
    assign cpu_in.wdata  = in_wdata;
    assign cpu_out.ready = out_ready;

    video_processor_cpu_ports dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cpu_in),
        .o_out   (cpu_out)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Transactions waiting to be offered, and replies that the predictor has
    // worked out but the block has not yet returned.
    t_port_access access_queue[$];
    t_port_reply  due_replies[$];

    int taken = 0;
    int errors = 0;
    int cycles = 0;
    int in_gap = 0;
    int out_hold = 0;

    // Shadow state of the port logic. It is brought to its power-on values
    // by the driver while reset is held, exactly as the block clears itself.
    logic [7:0] vram_copy [VRAM_BYTES];
    logic [7:0] regs_copy [64];
    logic [7:0] stat_copy [10];
    logic [8:0] pal_copy [16];
    t_vaddr     shadow_addr;
    logic [7:0] fetched_byte;
    logic [7:0] ctl_first;
    logic       ctl_held;
    logic [7:0] pal_first;
    logic       pal_held;

    // Bursts of idling are allowed for two thirds of every 150 transactions,
    // leaving calm stretches in between, and never near the end of the run.
    function automatic bit stalls_allowed();
        return (taken % 150) < 100 && access_queue.size() > 40;
    endfunction

    // Advances the access address. Only a handful of display modes use all
    // 17 bits; every other mode wraps within the low 14 bits and keeps the
    // top three untouched.
    function automatic void step_addr();
        logic wide;
        case ({regs_copy[REG_MODE0][3:1], regs_copy[REG_MODE1][3], regs_copy[REG_MODE1][4]})
            5'h08, 5'h09, 5'h0C, 5'h10, 5'h14, 5'h1C: wide = 1'b1;
            default: wide = 1'b0;
        endcase
        if (wide) begin
            shadow_addr = shadow_addr + t_vaddr'(1);
        end else begin
            shadow_addr[13:0] = shadow_addr[13:0] + 14'd1;
        end
    endfunction

    // Writes a register and applies its side effects. Returns the interrupt
    // flag, which is raised when the interrupt enable of register 1 turns on
    // while the frame flag is already pending.
    function automatic logic set_reg(input logic [5:0] n, input logic [7:0] v);
        logic irq;
        irq = (n == REG_MODE1) && !regs_copy[REG_MODE1][5] && v[5] && stat_copy[ST_FRAME][7];
        regs_copy[n] = v;
        if (n == REG_ADDR_HI) begin
            shadow_addr[16:14] = v[2:0];
        end else if (n == REG_PAL_PTR) begin
            pal_held = 1'b0;
        end
        return irq;
    endfunction

    // A 3-bit colour channel spread over 8 bits by repeating its pattern.
    function automatic logic [7:0] widen(input logic [2:0] c);
        return (8'(c) << 5) | (8'(c) << 2) | (8'(c) >> 1);
    endfunction

    // Applies one accepted transaction to the shadow state and queues the
    // reply that the block must give for it.
    task automatic cpu_access(input logic [2:0] fn, input logic [7:0] wd);
        t_port_reply r;
        logic [5:0]  n;
        logic [3:0]  sel;
        logic [3:0]  idx;
        logic [8:0]  p;
        r = '0;
        case (fn)
            FN_DREAD: begin
                // The byte returned is the one fetched ahead; the buffer is
                // then refilled from the current address.
                ctl_held = 1'b0;
                r.rdata = fetched_byte;
                fetched_byte = vram_copy[shadow_addr];
                step_addr();
            end
            FN_DWRITE: begin
                ctl_held = 1'b0;
                vram_copy[shadow_addr] = wd;
                step_addr();
            end
            FN_CTRL: begin
                if (!ctl_held) begin
                    ctl_first = wd;
                    ctl_held = 1'b1;
                end else begin
                    ctl_held = 1'b0;
                    if (wd[7]) begin
                        r.irq = set_reg(wd[5:0], ctl_first);
                    end else begin
                        shadow_addr = {regs_copy[REG_ADDR_HI][2:0], wd[5:0], ctl_first};
                        // A read setup fetches the first byte at once.
                        if (!wd[6]) begin
                            fetched_byte = vram_copy[shadow_addr];
                            step_addr();
                        end
                    end
                end
            end
            FN_STATUS: begin
                ctl_held = 1'b0;
                sel = regs_copy[REG_STATUS_SEL][3:0];
                if (sel > ST_SEL_MAX) begin
                    r.rdata = ST_OUT_RANGE;
                end else begin
                    r.rdata = stat_copy[sel];
                    if (sel == ST_FRAME) begin
                        stat_copy[ST_FRAME] = 8'h00;
                    end else if (sel == ST_LINE) begin
                        stat_copy[ST_LINE][0] = 1'b0;
                    end
                end
            end
            FN_PALETTE: begin
                if (!pal_held) begin
                    pal_first = wd;
                    pal_held = 1'b1;
                end else begin
                    idx = regs_copy[REG_PAL_PTR][3:0];
                    pal_held = 1'b0;
                    pal_copy[idx] = {pal_first[6:4], wd[2:0], pal_first[2:0]};
                    regs_copy[REG_PAL_PTR] = {4'h0, idx + 4'd1};
                end
            end
            FN_INDIRECT: begin
                // The pointer register itself is never the target.
                n = regs_copy[REG_INDIRECT][5:0];
                if (n != REG_INDIRECT) begin
                    r.irq = set_reg(n, wd);
                end
                if (!regs_copy[REG_INDIRECT][7]) begin
                    regs_copy[REG_INDIRECT] = {regs_copy[REG_INDIRECT][7], 1'b0, n + 6'd1};
                end
            end
            FN_VBLANK: begin
                stat_copy[ST_FRAME][7] = 1'b1;
                stat_copy[ST_VSTAT][6] = 1'b1;
                r.irq = regs_copy[REG_MODE1][5];
            end
            default: begin
            end
        endcase
        // The backdrop colour is taken after the transaction has taken effect.
        p = pal_copy[regs_copy[REG_BACKDROP][3:0]];
        r.rgb = {widen(p[8:6]), widen(p[5:3]), widen(p[2:0])};
        due_replies.push_back(r);
    endtask

    // Driver: offers the queued transactions, holding each until it is taken,
    // and feeds every accepted one to the predictor at the edge of acceptance.
    always @(posedge i_clk) begin
        t_port_access next;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            for (int i = 0; i < VRAM_BYTES; i++) begin
                vram_copy[i] = 8'h00;
            end
            for (int i = 0; i < 64; i++) begin
                regs_copy[i] = 8'h00;
            end
            for (int i = 0; i < 10; i++) begin
                stat_copy[i] = 8'h00;
            end
            stat_copy[ST_VSTAT] = ST_VSTAT_RESET;
            for (int i = 0; i < 16; i++) begin
                pal_copy[i] = BOOT_PALETTE[i];
            end
            shadow_addr = '0;
            fetched_byte = 8'h00;
            ctl_first = 8'h00;
            ctl_held = 1'b0;
            pal_first = 8'h00;
            pal_held = 1'b0;
        end else begin
            if (in_valid && cpu_in.ready) begin
                cpu_access(in_func, in_wdata);
                taken++;
            end
            if (!in_valid || cpu_in.ready) begin
                if (in_gap > 0 || access_queue.size() == 0) begin
                    if (in_gap > 0) begin
                        in_gap--;
                    end
                    in_valid <= 1'b0;
                end else begin
                    next = access_queue.pop_front();
                    in_valid <= 1'b1;
                    in_func <= next.fn;
                    in_wdata <= next.wd;
                    if (stalls_allowed() && $urandom_range(0, 3) == 0) begin
                        in_gap = $urandom_range(1, 4);
                    end
                end
            end
        end
    end

    // Monitor: takes the replies, with stalls of its own, and checks each one
    // field by field against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_port_reply want;
        logic        ready_next;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (cpu_out.valid && out_ready) begin
                if (due_replies.size() == 0) begin
                    $error("reply with no transaction outstanding: rdata %02h irq %0b rgb %06h",
                           cpu_out.rdata, cpu_out.irq_pulse, cpu_out.backdrop_rgb);
                    errors++;
                end else begin
                    want = due_replies.pop_front();
                    if (cpu_out.rdata !== want.rdata) begin
                        $error("rdata: expected %02h, got %02h", want.rdata, cpu_out.rdata);
                        errors++;
                    end
                    if (cpu_out.irq_pulse !== want.irq) begin
                        $error("irq_pulse: expected %0b, got %0b", want.irq, cpu_out.irq_pulse);
                        errors++;
                    end
                    if (cpu_out.backdrop_rgb !== want.rgb) begin
                        $error("backdrop_rgb: expected %06h, got %06h",
                               want.rgb, cpu_out.backdrop_rgb);
                        errors++;
                    end
                end
            end
            if (out_hold > 0) begin
                out_hold--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
                if (stalls_allowed() && $urandom_range(0, 5) == 0) begin
                    out_hold = $urandom_range(1, 4);
                end
            end
            out_ready <= ready_next;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic push_access(input logic [2:0] fn, input logic [7:0] wd);
        access_queue.push_back('{fn: fn, wd: wd});
    endtask

    // A register write through the control port: value first, then the
    // register number with bit 7 set. Bit 6 of the second byte is don't-care.
    task automatic push_reg(input logic [5:0] n, input logic [7:0] v);
        push_access(FN_CTRL, v);
        push_access(FN_CTRL, {1'b1, 1'($urandom_range(0, 1)), n});
    endtask

    // An address setup through the control port; a read setup has bit 6 of
    // the second byte clear.
    task automatic push_setup(input logic [13:0] a, input logic rd);
        push_access(FN_CTRL, a[7:0]);
        push_access(FN_CTRL, {1'b0, ~rd, a[13:8]});
    endtask

    // Picks a low address: half the time anywhere, otherwise at or just below the 14-bit
    // wrap point or at the very start.
    function automatic logic [13:0] pick_addr();
        case ($urandom_range(0, 3))
            0: return 14'h3FFF - 14'($urandom_range(0, 3));
            1: return 14'($urandom_range(0, 3));
            default: return 14'($urandom_range(0, 16383));
        endcase
    endfunction

    initial begin
        logic [4:0]  mode;
        logic [7:0]  v;
        logic [7:0]  w;
        logic [13:0] a;
        logic [5:0]  n;
        int          k;
        int          total;

        // Directed opening. After reset the status selector is 0 and the
        // frame flag is clear.
        push_access(FN_STATUS, 8'hFF);
        // Indirect writes starting at register 15: an out-of-range status
        // selector, then the palette pointer, then the pointer register
        // itself, which must be skipped.
        push_reg(REG_INDIRECT, 8'h0F);
        push_access(FN_INDIRECT, 8'hFF);
        push_access(FN_STATUS, 8'h00);
        push_access(FN_INDIRECT, 8'h00);
        push_access(FN_INDIRECT, 8'hAA);
        // Frame flag set while interrupts are still disabled.
        push_access(FN_VBLANK, 8'h00);
        // Rewrite palette entry 0, which is the backdrop after reset.
        push_access(FN_PALETTE, 8'h70);
        push_access(FN_PALETTE, 8'h07);
        // Enabling interrupts with the frame flag pending raises one at once.
        push_reg(REG_MODE1, 8'h20);
        push_access(FN_VBLANK, 8'hFF);
        // Write and read back the last byte of a 14-bit page; the address
        // wraps to the start of the page.
        push_setup(14'h3FFF, 1'b0);
        push_access(FN_DWRITE, 8'hFF);
        push_setup(14'h3FFF, 1'b1);
        push_access(FN_DREAD, 8'h00);
        push_access(FN_UNUSED, 8'hFF);
        // A palette write between the two control bytes leaves the control
        // latch intact; this sets the high address bits to all ones.
        push_access(FN_CTRL, 8'h07);
        push_access(FN_PALETTE, 8'h12);
        push_access(FN_CTRL, {1'b1, 1'b0, REG_ADDR_HI});
        // A wide display mode, then a write at the top of video memory.
        push_reg(REG_MODE0, 8'h08);
        push_setup(14'h3FFF, 1'b0);
        push_access(FN_DWRITE, 8'h5A);

        // Random part, built mostly from well-formed control, palette and
        // indirect sequences with random content, plus some noise.
        total = access_queue.size() + RANDOM_ITEMS;
        while (access_queue.size() < total) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    // New display mode, half the time one of the wide modes.
                    mode = 5'($urandom_range(0, 31));
                    if ($urandom_range(0, 1) == 1) begin
                        case ($urandom_range(0, 5))
                            0: mode = 5'h08;
                            1: mode = 5'h09;
                            2: mode = 5'h0C;
                            3: mode = 5'h10;
                            4: mode = 5'h14;
                            default: mode = 5'h1C;
                        endcase
                    end
                    v = 8'($urandom_range(0, 255));
                    w = 8'($urandom_range(0, 255));
                    push_reg(REG_MODE0, {v[7:4], mode[4:2], v[0]});
                    push_reg(REG_MODE1, {w[7:5], mode[0], mode[1], w[2:0]});
                end
                2, 3: begin
                    case ($urandom_range(0, 7))
                        0: n = REG_MODE1;
                        1: n = REG_BACKDROP;
                        2: n = REG_ADDR_HI;
                        3: n = REG_STATUS_SEL;
                        4: n = REG_PAL_PTR;
                        5: n = REG_INDIRECT;
                        default: n = 6'($urandom_range(0, 63));
                    endcase
                    v = 8'($urandom_range(0, 255));
                    if (n == REG_STATUS_SEL && $urandom_range(0, 3) != 0) begin
                        v[3:0] = 4'($urandom_range(0, 9));
                    end
                    push_reg(n, v);
                end
                4, 5, 6, 7: begin
                    // Burst of writes, often read back from the same address.
                    if ($urandom_range(0, 2) == 0) begin
                        v = 8'($urandom_range(0, 255));
                        if ($urandom_range(0, 2) == 0) begin
                            v[2:0] = 3'h7;
                        end
                        push_reg(REG_ADDR_HI, v);
                    end
                    a = pick_addr();
                    k = $urandom_range(1, 8);
                    push_setup(a, 1'b0);
                    repeat (k) push_access(FN_DWRITE, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 1) == 1) begin
                        push_setup(a, 1'b1);
                        repeat (k) push_access(FN_DREAD, 8'($urandom_range(0, 255)));
                    end
                end
                8, 9, 10: begin
                    push_setup(pick_addr(), 1'b1);
                    repeat ($urandom_range(1, 8)) begin
                        push_access(FN_DREAD, 8'($urandom_range(0, 255)));
                    end
                end
                11, 12: begin
                    // Palette pair; a pointer write first drops any half pair.
                    if ($urandom_range(0, 3) == 0) begin
                        push_reg(REG_PAL_PTR, 8'($urandom_range(0, 255)));
                    end
                    push_access(FN_PALETTE, 8'($urandom_range(0, 255)));
                    push_access(FN_PALETTE, 8'($urandom_range(0, 255)));
                end
                13, 14: begin
                    v = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 1) == 1) begin
                        v[5:0] = 6'($urandom_range(12, 18));
                    end
                    push_reg(REG_INDIRECT, v);
                    repeat ($urandom_range(1, 4)) begin
                        push_access(FN_INDIRECT, 8'($urandom_range(0, 255)));
                    end
                end
                15: begin
                    if ($urandom_range(0, 1) == 1) begin
                        push_reg(REG_STATUS_SEL, 8'($urandom_range(0, 11)));
                    end
                    repeat ($urandom_range(1, 2)) begin
                        push_access(FN_STATUS, 8'($urandom_range(0, 255)));
                    end
                end
                16: push_access(FN_VBLANK, 8'($urandom_range(0, 255)));
                17: begin
                    // Half a control pair followed by anything at all.
                    push_access(FN_CTRL, 8'($urandom_range(0, 255)));
                    push_access(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                end
                default: begin
                    push_access(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                end
            endcase
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every transaction taken, every reply returned, then a short drain
        // to catch any reply the block might still produce.
        while (taken < total) @(posedge i_clk);
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/vpc_pkg.sv
rtl/vpc_in_if.sv
rtl/vpc_out_if.sv
rtl/vpc_ram.sv
rtl/vpc_front.sv
rtl/vpc_back.sv
rtl/video_processor_cpu_ports.sv
tb/testbench.sv
